// ===== rtl/tcp_flow_sentinel_segment_splitter_top_defines.svh =====
// Assertion macros for the segment splitter
`ifndef TCP_FLOW_SENTINEL_SEGMENT_SPLITTER_TOP_DEFINES_SVH
`define TCP_FLOW_SENTINEL_SEGMENT_SPLITTER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TFS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/tfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared types and constants of the segment splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tfs_pkg;
    localparam logic [1:0] ACT_FWD  = 2'd0;
    localparam logic [1:0] ACT_SPLIT = 2'd1;
    localparam logic [1:0] ACT_FULL = 2'd2;
    localparam logic [1:0] REG_SEG_SIZE = 2'd0;
    localparam logic [1:0] REG_SEG_ALL  = 2'd1;
    localparam logic [1:0] REG_REVERSE  = 2'd2;
    localparam logic [1:0] REG_MIX      = 2'd3;
    localparam logic [15:0] PORT_TLS  = 16'd443;
    localparam logic [15:0] PORT_HTTP = 16'd80;
    localparam logic [7:0]  TLS_HANDSHAKE = 8'h16;
    localparam logic [7:0]  TLS_HELLO     = 8'h01;
    localparam logic [23:0] HTTP_GET      = 24'h474554;
    localparam logic [10:0] MIN_SEG  = 11'd24;
    localparam logic [5:0]  MAX_SEGS = 6'd63;

    typedef struct packed {
        logic        later_fragment;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        syn_flag;
        logic [10:0] payload_length;
        logic [47:0] head_bytes;
        logic [31:0] seq_number;
        logic [15:0] ip_total_length;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  action;
        logic [10:0] seg_offset;
        logic [10:0] seg_length;
        logic [31:0] seg_seq;
        logic [15:0] seg_ip_length;
        logic        last;
    } t_out_word;
endpackage

// ===== rtl/tfs_stream_if.sv =====
// ----------------------------------------------------------------------------
// tfs_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface tfs_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tfs_ram.sv =====
// ----------------------------------------------------------------------------
// tfs_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== rtl/tcp_flow_sentinel_segment_splitter_top.sv =====
// ----------------------------------------------------------------------------
// tcp_flow_sentinel_segment_splitter_top
// A packet is accepted in S_IDLE and its flow key is searched in S_SEARCH; S_DECIDE
// then sends it to S_SINGLE for one forwarded word, or through S_CAP and S_PLAN to
// S_EMIT for a split. One packet at a time: a new one is accepted only in S_IDLE.
// The output word holds while the output stalls. Reset: synchronous, active low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tcp_flow_sentinel_segment_splitter_top_defines.svh"
module tcp_flow_sentinel_segment_splitter_top #(
    parameter int FLOW_SLOTS  = 64,
    parameter int MAX_PAYLOAD = 1500
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfs_stream_if.sink   in_if,
    tfs_stream_if.source out_if,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    localparam int SW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
    localparam int CW = $clog2(FLOW_SLOTS + 1);
    localparam logic [10:0] MAXP = 11'(MAX_PAYLOAD > 2047 ? 2047 : MAX_PAYLOAD);
    // 2^18 / 63 rounded up; exact for ceil(plen / 63) over 11-bit payloads
    localparam logic [12:0] CAP_RECIP = 13'd4162;

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_DECIDE, S_CAP, S_PLAN, S_EMIT, S_SINGLE
    } t_state;

    t_state r_state;
    tfs_pkg::t_in_word r_pkt;
    logic [10:0] r_seg_size;
    logic        r_seg_all, r_reverse, r_mix;
    logic [FLOW_SLOTS-1:0] r_valid, r_seen;
    logic [CW-1:0] r_cnt;
    logic          r_rd_pend;
    logic [SW-1:0] r_rd_slot;
    logic          r_found;
    logic [SW-1:0] r_slot;
    logic [1:0]  r_fwd_act;
    logic [10:0] r_plen, r_seg, r_off;
    logic [5:0]  r_n, r_k;
    tfs_pkg::t_out_word r_out;
    logic r_out_valid;

    // key memory: one slot read per cycle during the search
    logic          mem_we;
    logic [SW-1:0] mem_addr, free_slot;
    logic [95:0]   mem_rdata;
    logic          has_free;
    logic          syn_new;

    always_comb begin
        free_slot = '0;
        has_free = 1'b0;
        for (int i = FLOW_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = SW'(i);
                has_free = 1'b1;
            end
        end
    end

    // sentinel check on the captured packet
    logic tls_hit, http_hit, tracked, sentinel_hit;
    always_comb begin
        tls_hit = (r_pkt.payload_length >= 11'd6)
            && (r_pkt.head_bytes[47:40] == tfs_pkg::TLS_HANDSHAKE)
            && (r_pkt.head_bytes[7:0] == tfs_pkg::TLS_HELLO);
        http_hit = (r_pkt.payload_length >= 11'd3)
            && (r_pkt.head_bytes[47:24] == tfs_pkg::HTTP_GET);
        tracked = !r_pkt.later_fragment && ((r_pkt.dst_port == tfs_pkg::PORT_TLS)
            || (r_pkt.dst_port == tfs_pkg::PORT_HTTP));
        sentinel_hit = (r_pkt.dst_port == tfs_pkg::PORT_TLS) ? tls_hit : http_hit;
    end

    assign syn_new = (r_state == S_DECIDE) && tracked && r_pkt.syn_flag && !r_found;
    assign mem_we = syn_new && has_free;
    assign mem_addr = mem_we ? free_slot : SW'(r_cnt);

    tfs_ram #(.WIDTH(96), .DEPTH(FLOW_SLOTS)) u_keys (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata({r_pkt.src_addr, r_pkt.dst_addr, r_pkt.src_port, r_pkt.dst_port}),
        .o_rdata(mem_rdata)
    );

    // segment cap: ceil(plen / 63) by reciprocal multiply
    logic [11:0] cap_num;
    logic [24:0] cap_prod;
    logic [10:0] cap_seg;
    assign cap_num = {1'b0, r_plen} + 12'(tfs_pkg::MAX_SEGS - 6'd1);
    assign cap_prod = {13'd0, cap_num} * {12'd0, CAP_RECIP};
    assign cap_seg = {4'd0, cap_prod[24:18]};

    // plan step helpers
    logic [10:0] rem, chunk;
    assign rem = r_plen - r_off;
    assign chunk = (rem < r_seg) ? rem : r_seg;

    // emit order: mixed queue holds odd segments descending, then even ascending (reverse swaps odd and even)
    logic [5:0]  n_odd, n_even, k_rev, odd_down, even_up, even_down, odd_up, emit_idx;
    logic [16:0] emit_prod;
    logic [10:0] emit_off, emit_rem, emit_len;
    always_comb begin
        n_odd = {1'b0, r_n[5:1]};
        n_even = r_n - n_odd;
        k_rev = r_n - 6'd1 - r_k;
        odd_down = n_odd - 6'd1 - r_k;
        even_up = r_k - n_odd;
        even_down = n_even - 6'd1 - r_k;
        odd_up = r_k - n_even;
        if (!r_mix) begin
            emit_idx = r_reverse ? k_rev : r_k;
        end else if (!r_reverse) begin
            emit_idx = (r_k < n_odd) ? {odd_down[4:0], 1'b1} : {even_up[4:0], 1'b0};
        end else begin
            emit_idx = (r_k < n_even) ? {even_down[4:0], 1'b0} : {odd_up[4:0], 1'b1};
        end
        emit_prod = {11'd0, emit_idx} * {6'd0, r_seg};
        emit_off = emit_prod[10:0];
        emit_rem = r_plen - emit_off;
        emit_len = (emit_rem < r_seg) ? emit_rem : r_seg;
    end

    logic out_free, out_load;
    assign out_free = !r_out_valid || out_if.ready;
    assign out_load = out_free && ((r_state == S_EMIT) || (r_state == S_SINGLE));
    assign in_if.ready = (r_state == S_IDLE);
    assign out_if.valid = r_out_valid;
    assign out_if.data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seg_size <= tfs_pkg::MIN_SEG;
            r_seg_all <= 1'b0;
            r_reverse <= 1'b0;
            r_mix <= 1'b0;
            r_valid <= '0;
            r_seen <= '0;
            r_out_valid <= 1'b0;
            r_rd_pend <= 1'b0;
            r_found <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tfs_pkg::REG_SEG_SIZE: r_seg_size <= i_cfg_data;
                    tfs_pkg::REG_SEG_ALL:  r_seg_all <= i_cfg_data[0];
                    tfs_pkg::REG_REVERSE:  r_reverse <= i_cfg_data[0];
                    tfs_pkg::REG_MIX:      r_mix <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // output register
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_if.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_if.valid) begin
                        r_pkt <= in_if.data;
                        r_cnt <= '0;
                        r_rd_pend <= 1'b0;
                        r_found <= 1'b0;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // compare the slot read last cycle
                    if (r_rd_pend && r_valid[r_rd_slot] && !r_found && mem_rdata ==
                        {r_pkt.src_addr, r_pkt.dst_addr, r_pkt.src_port, r_pkt.dst_port}) begin
                        r_found <= 1'b1;
                        r_slot <= r_rd_slot;
                    end
                    r_rd_slot <= SW'(r_cnt);
                    if (r_cnt == CW'(FLOW_SLOTS)) begin
                        r_rd_pend <= 1'b0;
                        r_state <= S_DECIDE;
                    end else begin
                        r_rd_pend <= 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DECIDE: begin
                    r_plen <= (r_pkt.payload_length > MAXP) ? MAXP : r_pkt.payload_length;
                    r_seg <= (r_seg_size < tfs_pkg::MIN_SEG) ? tfs_pkg::MIN_SEG : r_seg_size;
                    r_fwd_act <= (syn_new && !has_free) ? tfs_pkg::ACT_FULL : tfs_pkg::ACT_FWD;
                    if (syn_new && has_free) begin
                        r_valid[free_slot] <= 1'b1;
                        r_seen[free_slot] <= 1'b0;
                    end
                    if (tracked && !r_pkt.syn_flag && r_found && sentinel_hit) begin
                        r_seen[r_slot] <= 1'b1;
                    end
                    if (tracked && !r_pkt.syn_flag && r_found
                        && (sentinel_hit || (r_seen[r_slot] && r_seg_all))) begin
                        r_state <= S_CAP;
                    end else begin
                        r_state <= S_SINGLE;
                    end
                end
                S_CAP: begin
                    if (r_seg < cap_seg) begin
                        r_seg <= cap_seg;
                    end
                    r_off <= '0;
                    r_n <= '0;
                    r_state <= S_PLAN;
                end
                S_PLAN: begin
                    // count segments, one per cycle
                    if (r_off < r_plen && r_n < tfs_pkg::MAX_SEGS) begin
                        r_off <= r_off + chunk;
                        r_n <= r_n + 6'd1;
                    end else begin
                        r_k <= '0;
                        r_state <= (r_n == '0) ? S_IDLE : S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out <= '{action: tfs_pkg::ACT_SPLIT, seg_offset: emit_off,
                                   seg_length: emit_len,
                                   seg_seq: r_pkt.seq_number + {21'd0, emit_off},
                                   seg_ip_length: r_pkt.ip_total_length
                                       - {5'd0, r_plen} + {5'd0, emit_len},
                                   last: (r_k + 6'd1 == r_n)};
                        r_k <= r_k + 6'd1;
                        if (r_k + 6'd1 == r_n) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SINGLE: begin
                    if (out_free) begin
                        r_out <= '{action: r_fwd_act, seg_offset: '0, seg_length: '0,
                                   seg_seq: '0, seg_ip_length: '0, last: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TFS_ASSERT_IMPL(a_in_only_idle, i_clk, i_rst_n, in_if.ready, r_state == S_IDLE)
    `TFS_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, (r_state == S_EMIT) && out_free, r_out_valid)
    `TFS_ASSERT_IMPL(a_emit_count, i_clk, i_rst_n, r_state == S_EMIT, r_k < r_n)
    `TFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !out_if.ready, r_out_valid && $stable(r_out))
endmodule
